// ===== rtl/core/plkc_pkg.sv =====
package plkc_pkg;

    localparam int KEY_WORDS = 4;
    localparam int WORD_W    = 32;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

    typedef struct packed {
        logic shift;
        logic kill;
    } cell_ctl_t;

    // Float equality on raw single-precision bits: NaN never matches, +0 == -0.
    function automatic logic word_eq(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        logic [WORD_W-2:0] ma;
        logic [WORD_W-2:0] mb;
        logic              nan_a;
        logic              nan_b;
        ma    = a[WORD_W-2:0];
        mb    = b[WORD_W-2:0];
        nan_a = (ma > 31'h7F80_0000);
        nan_b = (mb > 31'h7F80_0000);
        if (nan_a || nan_b)
        begin
            return 1'b0;
        end
        if ((ma == '0) && (mb == '0))
        begin
            return 1'b1;
        end
        return (a == b);
    endfunction

    function automatic logic key_eq(input key_t a, input key_t b);
        logic eq;
        eq = 1'b1;
        for (int w = 0; w < KEY_WORDS; w++)
        begin
            eq = eq & word_eq(a[w], b[w]);
        end
        return eq;
    endfunction

endpackage

// ===== rtl/core/plane_keyed_lru_cache.sv =====
// Channel  Dir  tdata, low bits first                                   tuser             tlast
// s_*      in   plane_nx, plane_ny, plane_nz, plane_dist, new_handle    action            -
// m_*      out  found_handle, freed_handle                              hit, freed_valid  last
//
// A request is registered on acceptance; once the output register is free, it is compared
// against every cell of the chain at once and the chain shifts.
// A clear frees one handle per cycle while the output is not stalled, oldest first,
// taken from the deepest valid cell. Cell 0 is the most recently used entry.
// Reset empties the chain at once; key and handle storage is not cleared.
// A stalled result holds in the output register and holds the request behind it.
module plane_keyed_lru_cache
    import plkc_pkg::*;
#(
    parameter int CAPACITY     = 10,
    parameter int HANDLE_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // plane_nx, plane_ny, plane_nz, plane_dist, new_handle
    input  logic [1:0]   s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // found_handle, freed_handle
    output logic [1:0]   m_tuser,  // hit, freed_valid
    output logic         m_tlast
);

    localparam int HW = HANDLE_WIDTH;

    // request register
    logic          req_valid_reg, req_valid_next;
    action_t       req_action_reg;
    key_t          req_key_reg;
    logic [HW-1:0] req_handle_reg;

    // output register
    logic          m_tvalid_reg, m_tvalid_next;
    logic [63:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg, m_tuser_next;
    logic          m_tlast_reg, m_tlast_next;

    // chain
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_match;
    logic [CAPACITY-1:0] cell_lastv;
    logic [CAPACITY-1:0] cell_prefix;
    key_t                cell_key    [CAPACITY];
    logic [HW-1:0]       cell_handle [CAPACITY];
    cell_ctl_t           cell_ctl    [CAPACITY];

    logic          out_free;
    logic          process;
    logic          is_clear;
    logic          is_lu;
    logic          any_hit;
    logic          ins_new;
    logic          empty;
    logic          full;
    logic [HW-1:0] hit_handle;
    key_t          hit_key;
    logic [HW-1:0] last_handle;
    key_t          front_key;
    logic [HW-1:0] front_handle;
    logic [HW-1:0] freed_h;
    logic [HW-1:0] found_h;
    logic [HW+31:0] in_handle_ext;
    logic [HW+31:0] found_ext;
    logic [HW+31:0] freed_ext;

    assign in_handle_ext = {{HW{1'b0}}, s_tdata[159:128]};
    assign out_free      = !m_tvalid_reg || m_tready;
    assign s_tready      = !req_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_action_reg <= action_t'(s_tuser);
            req_key_reg    <= s_tdata[127:0];
            req_handle_reg <= in_handle_ext[HW-1:0];
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                plkc_cell #(.HANDLE_WIDTH(HW)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl       (cell_ctl[gi]),
                    .in_valid  (1'b1),
                    .in_key    (front_key),
                    .in_handle (front_handle),
                    .query_key (req_key_reg),
                    .q_valid   (cell_valid[gi]),
                    .q_key     (cell_key[gi]),
                    .q_handle  (cell_handle[gi]),
                    .match     (cell_match[gi])
                );
            end
            else
            begin : g_body
                plkc_cell #(.HANDLE_WIDTH(HW)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl       (cell_ctl[gi]),
                    .in_valid  (cell_valid[gi-1]),
                    .in_key    (cell_key[gi-1]),
                    .in_handle (cell_handle[gi-1]),
                    .query_key (req_key_reg),
                    .q_valid   (cell_valid[gi]),
                    .q_key     (cell_key[gi]),
                    .q_handle  (cell_handle[gi]),
                    .match     (cell_match[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        process  = req_valid_reg && out_free;
        is_clear = (req_action_reg == ACT_CLEAR);
        is_lu    = (req_action_reg == ACT_LOOKUP) || (req_action_reg == ACT_INSERT);
        any_hit  = |cell_match;
        empty    = !cell_valid[0];
        full     = cell_valid[CAPACITY-1];
        ins_new  = (req_action_reg == ACT_INSERT) && !any_hit && (req_handle_reg != '0);

        hit_handle  = '0;
        hit_key     = '0;
        last_handle = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_handle  = hit_handle | ({HW{cell_match[i]}} & cell_handle[i]);
            hit_key     = hit_key | ({($bits(key_t)){cell_match[i]}} & cell_key[i]);
            if (i == CAPACITY - 1)
            begin
                cell_lastv[i] = cell_valid[i];
            end
            else
            begin
                cell_lastv[i] = cell_valid[i] && !cell_valid[i+1];
            end
            last_handle = last_handle | ({HW{cell_lastv[i]}} & cell_handle[i]);
        end

        // cells from the front up to and including the hit shift one place deeper
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (i == CAPACITY - 1)
            begin
                cell_prefix[i] = cell_match[i];
            end
            else
            begin
                cell_prefix[i] = cell_match[i] | cell_prefix[i+1];
            end
        end

        front_key    = any_hit ? hit_key : req_key_reg;
        front_handle = any_hit ? hit_handle : req_handle_reg;

        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctl[i].shift = process && ((is_lu && cell_prefix[i]) || ins_new);
            cell_ctl[i].kill  = process && is_clear && cell_lastv[i];
        end

        found_h = (is_lu && any_hit) ? hit_handle : '0;
        if (ins_new && full)
        begin
            freed_h = cell_handle[CAPACITY-1];
        end
        else if (is_clear && !empty)
        begin
            freed_h = last_handle;
        end
        else
        begin
            freed_h = '0;
        end
        found_ext = {32'd0, found_h};
        freed_ext = {32'd0, freed_h};

        req_valid_next = req_valid_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;

        if (s_tvalid && s_tready)
        begin
            req_valid_next = 1'b1;
        end

        if (process)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {freed_ext[31:0], found_ext[31:0]};
            m_tuser_next  = {(ins_new && full) || (is_clear && !empty), is_lu && any_hit};
            m_tlast_next  = !is_clear || empty || cell_lastv[0];
            if (!is_clear || empty || cell_lastv[0])
            begin
                req_valid_next = 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |-> $onehot0(cell_match))
        else $error("more than one cell matches the key");

    a_packed_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, cell_valid} & ({1'b0, cell_valid} + 1'b1)) == '0))
        else $error("valid cells are not packed at the front of the chain");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (process && is_clear && m_tlast_next) |=> !cell_valid[0])
        else $error("chain not empty after clear");

    a_insert_front: assert property (@(posedge clk) disable iff (!rst_n)
        (process && ins_new) |=> cell_valid[0])
        else $error("inserted entry missing from front cell");
`endif

endmodule

// ===== rtl/core/plkc_cell.sv =====
module plkc_cell
    import plkc_pkg::*;
#(
    parameter int HANDLE_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctl_t               ctl,
    input  logic                    in_valid,
    input  key_t                    in_key,
    input  logic [HANDLE_WIDTH-1:0] in_handle,
    input  key_t                    query_key,
    output logic                    q_valid,
    output key_t                    q_key,
    output logic [HANDLE_WIDTH-1:0] q_handle,
    output logic                    match
);

    logic                    valid_reg;
    key_t                    key_reg;
    logic [HANDLE_WIDTH-1:0] handle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.kill)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= in_valid;
        end
    end

    // take the neighbor's entry on a shift
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            key_reg    <= in_key;
            handle_reg <= in_handle;
        end
    end

    assign match    = valid_reg && key_eq(key_reg, query_key);
    assign q_valid  = valid_reg;
    assign q_key    = key_reg;
    assign q_handle = handle_reg;

endmodule

// ===== tb/sv/plane_keyed_lru_cache_test.sv =====
`timescale 1ns / 1ps

module plane_keyed_lru_cache_test
    import plkc_pkg::*;
();

    localparam int CAPACITY   = 10;
    localparam int POOL_SIZE  = 14;
    localparam int RAND_ITEMS = 420;

    typedef logic [3:0][31:0] plane_t;

    typedef struct {
        action_t     act;
        plane_t      plane;
        logic [31:0] handle;
        bit          hold;
    } cache_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] found;
        logic        freed_v;
        logic [31:0] freed;
        logic        last;
    } cache_reply_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata  = '0;  // plane_nx, plane_ny, plane_nz, plane_dist, new_handle
    logic [1:0]   s_tuser  = ACT_LOOKUP;  // action
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;  // found_handle, freed_handle
    logic [1:0]   m_tuser;  // hit, freed_valid
    logic         m_tlast;

    plane_keyed_lru_cache dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the cache contents
    bit          shadow_valid [CAPACITY];
    plane_t      shadow_plane [CAPACITY];
    logic [31:0] shadow_handle[CAPACITY];
    int          shadow_rank  [CAPACITY];

    cache_req_t   req_q[$];
    cache_reply_t reply_q[$];
    cache_req_t   cur_req;

    int  mismatch_count = 0;
    int  accepted_cnt   = 0;
    int  reply_cnt      = 0;
    int  hit_cnt        = 0;
    int  freed_cnt      = 0;
    int  clear_cnt      = 0;
    int  holds_done     = 0;
    int  burst_left;
    int  gap_left;
    int  stall_mode;
    int  mode_left;
    int  ready_cycle;
    logic offer;
    logic ready_next;

    function automatic bit float_equal(logic [31:0] a, logic [31:0] b);
        if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000)
        begin
            return 1'b0;
        end
        if (a[30:0] == '0 && b[30:0] == '0)
        begin
            return 1'b1;
        end
        return a == b;
    endfunction

    function automatic bit plane_matches(plane_t a, plane_t b);
        return float_equal(a[0], b[0]) && float_equal(a[1], b[1]) &&
               float_equal(a[2], b[2]) && float_equal(a[3], b[3]);
    endfunction

    function automatic int held_entries();
        int n;
        n = 0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (shadow_valid[i])
            begin
                n++;
            end
        end
        return n;
    endfunction

    task automatic expect_reply(input cache_reply_t rp);
        reply_q = {reply_q, rp};
    endtask

    task automatic predict_reply(input cache_req_t rq);
        cache_reply_t rp;
        int held;
        int slot;
        int old_rank;
        rp = '0;
        if (rq.act == ACT_CLEAR)
        begin
            clear_cnt++;
            held = held_entries();
            if (held == 0)
            begin
                rp.last = 1'b1;
                expect_reply(rp);
            end
            // oldest entry first
            for (int r = held - 1; r >= 0; r--)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (shadow_valid[i] && shadow_rank[i] == r)
                    begin
                        rp         = '0;
                        rp.freed_v = 1'b1;
                        rp.freed   = shadow_handle[i];
                        rp.last    = (r == 0);
                        expect_reply(rp);
                    end
                end
            end
            for (int i = 0; i < CAPACITY; i++)
            begin
                shadow_valid[i] = 1'b0;
            end
            return;
        end
        rp.last = 1'b1;
        if (rq.act == ACT_NOP)
        begin
            expect_reply(rp);
            return;
        end
        slot = -1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot < 0 && shadow_valid[i] && plane_matches(shadow_plane[i], rq.plane))
            begin
                slot = i;
            end
        end
        if (slot >= 0)
        begin
            // move to front
            old_rank = shadow_rank[slot];
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (shadow_valid[i] && shadow_rank[i] < old_rank)
                begin
                    shadow_rank[i]++;
                end
            end
            shadow_rank[slot] = 0;
            rp.hit   = 1'b1;
            rp.found = shadow_handle[slot];
            expect_reply(rp);
            return;
        end
        if (rq.act == ACT_LOOKUP || rq.handle == '0)
        begin
            expect_reply(rp);
            return;
        end
        held = held_entries();
        if (held >= CAPACITY)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (slot < 0 && shadow_valid[i] && shadow_rank[i] == CAPACITY - 1)
                begin
                    rp.freed_v      = 1'b1;
                    rp.freed        = shadow_handle[i];
                    shadow_valid[i] = 1'b0;
                    slot            = i;
                end
            end
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot < 0 && !shadow_valid[i])
            begin
                slot = i;
            end
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (shadow_valid[i])
            begin
                shadow_rank[i]++;
            end
        end
        shadow_valid[slot]  = 1'b1;
        shadow_plane[slot]  = rq.plane;
        shadow_handle[slot] = rq.handle;
        shadow_rank[slot]   = 0;
        expect_reply(rp);
    endtask

    // request driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_reply(cur_req);
                accepted_cnt++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (req_q.size() > 0 && req_q[0].hold)
                begin
                    // hold off until every reply has drained
                    if (reply_q.size() == 0)
                    begin
                        void'(req_q.pop_front());
                        holds_done++;
                    end
                end
                else if (req_q.size() > 0)
                begin
                    cur_req = req_q.pop_front();
                    s_tdata <= {cur_req.handle, cur_req.plane};
                    s_tuser <= cur_req.act;
                    offer = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            s_tvalid <= offer;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // reply monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_mode  = 0;
            mode_left   = 0;
            ready_cycle = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                reply_cnt++;
                if (reply_q.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none, got tdata %h tuser %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    cache_reply_t want;
                    want = reply_q.pop_front();
                    if (want.hit)
                    begin
                        hit_cnt++;
                    end
                    if (want.freed_v)
                    begin
                        freed_cnt++;
                    end
                    check_field("hit", 32'(want.hit), 32'(m_tuser[0]));
                    check_field("found_handle", want.found, m_tdata[31:0]);
                    check_field("freed_valid", 32'(want.freed_v), 32'(m_tuser[1]));
                    check_field("freed_handle", want.freed, m_tdata[63:32]);
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end
            else
            begin
                mode_left--;
            end
            ready_cycle++;
            case (stall_mode)
                0: ready_next = 1'b1;
                1: ready_next = 1'($urandom_range(0, 1));
                2: ready_next = (ready_cycle % 4 == 0);
                default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
            m_tready <= ready_next;
        end
    end

    task automatic push_req(input action_t act, input plane_t plane,
                            input logic [31:0] handle, input bit hold = 1'b0);
        cache_req_t rq;
        rq.act    = act;
        rq.plane  = plane;
        rq.handle = handle;
        rq.hold   = hold;
        req_q     = {req_q, rq};
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h3F80_0000;
            3: return 32'hBF80_0000;
            4: return 32'h7F80_0000;
            5: return 32'hFF80_0000;
            6: return 32'h7FC0_0000 | $urandom_range(0, 255);
            7: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic plane_t pick_plane();
        plane_t p;
        for (int w = 0; w < 4; w++)
        begin
            p[w] = pick_word();
        end
        return p;
    endfunction

    initial
    begin
        plane_t      key_pool[POOL_SIZE];
        plane_t      p;
        plane_t      nan_plane;
        plane_t      fill_plane;
        logic [31:0] h;
        int          roll;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty clear, miss, no-op, signed zeros, zero handle, NaN, eviction
        push_req(ACT_CLEAR, '0, '0);
        push_req(ACT_LOOKUP, '0, 32'h0000_0001);
        push_req(ACT_NOP, '1, 32'hFFFF_FFFF);
        push_req(ACT_INSERT, '0, 32'hFFFF_FFFF);
        push_req(ACT_LOOKUP, {4{32'h8000_0000}}, 32'h0000_0000);
        push_req(ACT_INSERT, {4{32'h8000_0000}}, 32'h0000_0005);
        p = {32'hBF80_0000, 32'h3F80_0000, 32'hFF80_0000, 32'h7F80_0000};
        push_req(ACT_INSERT, p, 32'h0000_0000);
        push_req(ACT_LOOKUP, p, 32'h0000_0001);
        nan_plane = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FC0_0000};
        push_req(ACT_INSERT, nan_plane, 32'h0000_0001);
        push_req(ACT_LOOKUP, nan_plane, 32'h0000_0001);
        for (int i = 0; i < 9; i++)
        begin
            fill_plane = {32'(i), 32'hFF80_0000, 32'h7F80_0000, 32'h3F80_0000 + 32'(i)};
            push_req(ACT_INSERT, fill_plane, 32'h0000_0100 + 32'(i));
        end
        push_req(ACT_INSERT, {4{32'h4040_0000}}, 32'h0000_0200);
        push_req(ACT_LOOKUP, {32'd0, 32'hFF80_0000, 32'h7F80_0000, 32'h3F80_0000},
                 32'h0000_0001);
        push_req(ACT_INSERT, {32'd3, 32'hFF80_0000, 32'h7F80_0000, 32'h3F80_0003},
                 32'hFFFF_FFFF);
        push_req(ACT_CLEAR, '0, '0);
        push_req(ACT_CLEAR, '1, 32'hFFFF_FFFF);
        push_req(ACT_LOOKUP, '0, '0, 1'b1);

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = pick_plane();
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 150 || n == 300)
            begin
                push_req(ACT_LOOKUP, '0, '0, 1'b1);
            end
            if ($urandom_range(0, 29) == 0)
            begin
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = pick_plane();
            end
            if ($urandom_range(0, 4) == 0)
            begin
                p = {$urandom, $urandom, $urandom, $urandom};
            end
            else
            begin
                p = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                // flip the sign of zero words, which must still match
                for (int w = 0; w < 4; w++)
                begin
                    if (p[w][30:0] == '0)
                    begin
                        p[w][31] = 1'($urandom_range(0, 1));
                    end
                end
            end
            case ($urandom_range(0, 11))
                0: h = '0;
                1: h = 32'hFFFF_FFFF;
                default: h = $urandom;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 44)
            begin
                push_req(ACT_LOOKUP, p, h);
            end
            else if (roll < 90)
            begin
                push_req(ACT_INSERT, p, h);
            end
            else if (roll < 96)
            begin
                push_req(ACT_CLEAR, p, h);
            end
            else
            begin
                push_req(ACT_NOP, p, h);
            end
        end

        while (req_q.size() > 0 || s_tvalid || reply_q.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);

        if (reply_q.size() != 0)
        begin
            $display("%0t: %0d replies never arrived, expected 0 outstanding, got %0d",
                     $time, reply_q.size(), reply_q.size());
            mismatch_count++;
        end
        $display("Checked %0d requests (%0d clears, %0d drain pauses) and %0d replies",
                 accepted_cnt, clear_cnt, holds_done, reply_cnt);
        $display("Replies held %0d hits and %0d freed handles", hit_cnt, freed_cnt);
        if (mismatch_count == 0)
        begin
            $display("plane_keyed_lru_cache_test: PASS");
        end
        else
        begin
            $display("plane_keyed_lru_cache_test: FAIL");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d requests and %0d replies outstanding",
                 req_q.size(), reply_q.size());
        $display("plane_keyed_lru_cache_test: FAIL");
        $finish;
    end

endmodule
